// ===== rtl/aldl_pkg.sv =====
package aldl_pkg;

  localparam int unsigned CountW    = 16;
  localparam int unsigned NoiseW    = 17;
  localparam int unsigned LuxW      = 27;
  localparam int unsigned DividendW = 41;
  localparam int unsigned DenW      = 23;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned AccW      = 33;

  localparam logic [LuxW-1:0] LuxMaxQ8 = LuxW'(100000000);
  localparam logic [CountW-1:0] SatCount = 16'hFFFF;
  localparam logic signed [NoiseW-1:0] NoiseHiInit = 17'sd5;
  localparam logic signed [NoiseW-1:0] NoiseLoInit = -17'sd5;

  // Item kinds
  localparam logic [1:0] KindBaseline = 2'd0;
  localparam logic [1:0] KindNoiseCal = 2'd1;
  localparam logic [1:0] KindMeasure  = 2'd2;

  // Ratio bands
  localparam logic [1:0] BandLow  = 2'd0;
  localparam logic [1:0] BandMid  = 2'd1;
  localparam logic [1:0] BandHigh = 2'd2;
  localparam logic [1:0] BandZero = 2'd3;

  // Register indexes
  localparam logic [1:0] RegGain  = 2'd0;
  localparam logic [1:0] RegInteg = 2'd1;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DenW-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [LuxW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [6:0] gain_of(input logic [2:0] code);
    logic [6:0] g;
    unique case (code)
      3'd0: g = 7'd1;
      3'd1: g = 7'd2;
      3'd2: g = 7'd4;
      3'd3: g = 7'd8;
      3'd4: g = 7'd1;
      3'd5: g = 7'd1;
      3'd6: g = 7'd48;
      default: g = 7'd96;
    endcase
    return g;
  endfunction

  // Twice the integration factor
  function automatic logic [3:0] integ2_of(input logic [2:0] code);
    logic [3:0] t;
    unique case (code)
      3'd0: t = 4'd2;
      3'd1: t = 4'd1;
      3'd2: t = 4'd4;
      3'd3: t = 4'd8;
      3'd4: t = 4'd3;
      3'd5: t = 4'd5;
      3'd6: t = 4'd6;
      default: t = 4'd7;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/aldl_band.sv =====
module aldl_band (
  input  logic [aldl_pkg::CountW-1:0] ch0_i,
  input  logic [aldl_pkg::CountW-1:0] ch1_i,
  output logic [1:0]                  band_o
);
  import aldl_pkg::*;

  logic [CountW:0] sum;
  logic [23:0]     r100;
  logic [23:0]     s45;
  logic [23:0]     s64;
  logic [23:0]     s85;

  always_comb begin
    sum  = {1'b0, ch0_i} + {1'b0, ch1_i};
    r100 = {8'b0, ch1_i} * 24'd100;
    s45  = {7'b0, sum} * 24'd45;
    s64  = {7'b0, sum} * 24'd64;
    s85  = {7'b0, sum} * 24'd85;
    priority if (ch0_i == SatCount || ch1_i == SatCount) begin
      band_o = BandZero;
    end else if (r100 < s45) begin
      band_o = BandLow;
    end else if (r100 < s64) begin
      band_o = BandMid;
    end else if (r100 < s85) begin
      band_o = BandHigh;
    end else begin
      band_o = BandZero;
    end
  end

endmodule

// ===== rtl/aldl_div.sv =====
module aldl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aldl_pkg::div_req_t req_i,
  output aldl_pkg::div_rsp_t rsp_o
);
  import aldl_pkg::*;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_e;

  localparam int unsigned CntW = $clog2(LuxW);

  div_state_e      state_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] rem_q;
  logic [DenW-1:0] den_q;
  logic [LuxW-1:0] shift_q;
  logic            done_q;
  logic [DenW+1:0] trial;

  // One quotient bit a cycle; the dividend bits shift out as quotient bits shift in.
  assign trial = {1'b0, rem_q, shift_q[LuxW-1]} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        DIV_IDLE: begin
          if (req_i.start) begin
            state_q <= DIV_RUN;
            cnt_q   <= CntW'(LuxW - 1);
          end
        end
        DIV_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= DIV_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= DIV_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && req_i.start) begin
      // The top bits stay below the divisor, so the quotient fits LuxW bits.
      rem_q   <= DenW'(req_i.dividend[DividendW-1:LuxW]);
      shift_q <= req_i.dividend[LuxW-1:0];
      den_q   <= req_i.divisor;
    end else if (state_q == DIV_RUN) begin
      if (!trial[DenW+1]) begin
        rem_q <= trial[DenW-1:0];
      end else begin
        rem_q <= {rem_q[DenW-2:0], shift_q[LuxW-1]};
      end
      shift_q <= {shift_q[LuxW-2:0], ~trial[DenW+1]};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = shift_q;

endmodule

// ===== rtl/ambient_light_deadband_lux.sv =====
// Two-channel ambient light to lux converter with a noise deadband. Each input
// transfer carries a kind tag and raw channel 0 (visible plus IR) and channel 1
// (IR) counts; kind 0 captures a baseline and resets the noise bounds to -5/+5,
// kind 1 widens the noise bounds around that baseline, both load the held
// values, kind 2 moves a held value only when the sample leaves its deadband,
// and kind 3 leaves all state alone. Every transfer yields one result: lux in
// units of 1/256 from the held values, the ratio band, and the held counts.
// The deadband update happens at the input transfer itself. An item with a
// positive coefficient sum then takes one step for the band compare, two
// through the single shared 16x16 multiplier for the band coefficients, one
// to form the dividend and launch the divider, the bit-serial restoring
// divider that scales by the gain and integration-time tables, one to take
// the quotient and one to load the result. A zero or negative sum skips the
// divider. The input stalls from the transfer until the result is loaded, so
// no new item is taken before the result is loaded, and loading waits while
// the output register is full and stalled; a finished result may wait in the
// output register while the next item is taken. Gain and integration codes
// are to be written through the cfg port only while the block is idle; the
// block itself does not enforce it.
module ambient_light_deadband_lux (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [2:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [aldl_pkg::CountW-1:0] visible_ir_raw_i,
  input  logic [aldl_pkg::CountW-1:0] infrared_raw_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [aldl_pkg::LuxW-1:0]   lux_q8_o,
  output logic [1:0]                  ratio_band_o,
  output logic [aldl_pkg::CountW-1:0] held_visible_ir_o,
  output logic [aldl_pkg::CountW-1:0] held_infrared_o
);
  import aldl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAND,
    S_MUL_A,
    S_MUL_B,
    S_DIV_START,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  // Return the widened upper bound for one channel.
  function automatic logic signed [NoiseW-1:0] widen_hi(
    input logic [CountW-1:0]        s,
    input logic [CountW-1:0]        b,
    input logic signed [NoiseW-1:0] hi
  );
    logic signed [NoiseW:0] d;
    d = $signed({2'b0, s}) - $signed({2'b0, b});
    return (d > 0 && d > (NoiseW+1)'(hi)) ? d[NoiseW-1:0] : hi;
  endfunction

  function automatic logic signed [NoiseW-1:0] widen_lo(
    input logic [CountW-1:0]        s,
    input logic [CountW-1:0]        b,
    input logic signed [NoiseW-1:0] lo
  );
    logic signed [NoiseW:0] d;
    d = $signed({2'b0, s}) - $signed({2'b0, b});
    return (d < 0 && d < (NoiseW+1)'(lo)) ? d[NoiseW-1:0] : lo;
  endfunction

  // Jump to the sample when it leaves held+hi, then recheck against held+lo.
  function automatic logic [CountW-1:0] deadband(
    input logic [CountW-1:0]        s,
    input logic [CountW-1:0]        h,
    input logic signed [NoiseW-1:0] hi,
    input logic signed [NoiseW-1:0] lo
  );
    logic signed [NoiseW+1:0] s_x;
    logic [CountW-1:0]        h1;
    s_x = $signed({3'b0, s});
    h1  = (s_x > $signed({3'b0, h}) + (NoiseW+2)'(hi)) ? s : h;
    return (s_x < $signed({3'b0, h1}) + (NoiseW+2)'(lo)) ? s : h1;
  endfunction

  state_e state_q;

  logic [2:0] gain_code_q;
  logic [2:0] integ_code_q;

  logic [CountW-1:0]        held0_q, held1_q, base0_q, base1_q;
  logic signed [NoiseW-1:0] hi0_q, lo0_q, hi1_q, lo1_q;

  logic [1:0]             band_q;
  logic [1:0]             band_c;
  logic signed [AccW-1:0] acc_q;
  logic [DenW-1:0]        den_q;
  logic [DenW-1:0]        den_c;
  logic [9:0]             gain_integ;

  logic [15:0]      mul_x;
  logic [15:0]      mul_y;
  logic [ProdW-1:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic            out_valid_q;
  logic [LuxW-1:0] lux_q;
  logic [1:0]      out_band_q;
  logic [CountW-1:0] out_held0_q, out_held1_q;

  logic accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  aldl_band u_band (
    .ch0_i  (held0_q),
    .ch1_i  (held1_q),
    .band_o (band_c)
  );

  // Shared multiplier: the first coefficient times channel 0, then the second times channel 1.
  always_comb begin
    mul_y = (state_q == S_MUL_B) ? held1_q : held0_q;
    mul_x = 16'd0;
    unique case (band_q)
      BandLow:  mul_x = (state_q == S_MUL_B) ? 16'd11059 : 16'd17743;
      BandMid:  mul_x = (state_q == S_MUL_B) ? 16'd19548 : 16'd42785;
      BandHigh: mul_x = (state_q == S_MUL_B) ? 16'd1185  : 16'd5926;
      default:  mul_x = 16'd0;
    endcase
    prod = {16'b0, mul_x} * {16'b0, mul_y};
  end

  always_comb begin
    gain_integ = {3'b0, gain_of(gain_code_q)} * {6'b0, integ2_of(integ_code_q)};
    den_c      = {13'b0, gain_integ} * DenW'(10000);
  end

  assign div_req.start    = (state_q == S_DIV_START) && (acc_q > 0);
  assign div_req.divisor  = den_q;
  assign div_req.dividend = {acc_q[DividendW-10:0], 9'b0}
                          + {{(DividendW-DenW+1){1'b0}}, den_q[DenW-1:1]};

  aldl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_code_q  <= '0;
      integ_code_q <= '0;
    end else if (cfg_we_i) begin
      // Drop writes beyond the register list.
      if (cfg_idx_i == RegGain) begin
        gain_code_q <= cfg_data_i;
      end else if (cfg_idx_i == RegInteg) begin
        integ_code_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held0_q     <= '0;
      held1_q     <= '0;
      base0_q     <= '0;
      base1_q     <= '0;
      hi0_q       <= NoiseHiInit;
      hi1_q       <= NoiseHiInit;
      lo0_q       <= NoiseLoInit;
      lo1_q       <= NoiseLoInit;
      band_q      <= BandZero;
      den_q       <= '0;
      acc_q       <= '0;
      lux_q       <= '0;
      out_valid_q <= 1'b0;
      out_band_q  <= BandZero;
      out_held0_q <= '0;
      out_held1_q <= '0;
    end else begin
      // Load a finished result, or drop the one being taken.
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_BAND;
            unique case (kind_i)
              KindBaseline: begin
                base0_q <= visible_ir_raw_i;
                base1_q <= infrared_raw_i;
                hi0_q   <= NoiseHiInit;
                hi1_q   <= NoiseHiInit;
                lo0_q   <= NoiseLoInit;
                lo1_q   <= NoiseLoInit;
                held0_q <= visible_ir_raw_i;
                held1_q <= infrared_raw_i;
              end
              KindNoiseCal: begin
                hi0_q   <= widen_hi(visible_ir_raw_i, base0_q, hi0_q);
                lo0_q   <= widen_lo(visible_ir_raw_i, base0_q, lo0_q);
                hi1_q   <= widen_hi(infrared_raw_i, base1_q, hi1_q);
                lo1_q   <= widen_lo(infrared_raw_i, base1_q, lo1_q);
                held0_q <= visible_ir_raw_i;
                held1_q <= infrared_raw_i;
              end
              KindMeasure: begin
                held0_q <= deadband(visible_ir_raw_i, held0_q, hi0_q, lo0_q);
                held1_q <= deadband(infrared_raw_i, held1_q, hi1_q, lo1_q);
              end
              default: begin
                // Unused kind: hold all state.
              end
            endcase
          end
        end
        S_BAND: begin
          band_q  <= band_c;
          den_q   <= den_c;
          state_q <= S_MUL_A;
        end
        S_MUL_A: begin
          acc_q   <= $signed({1'b0, prod});
          state_q <= S_MUL_B;
        end
        S_MUL_B: begin
          if (band_q == BandMid) begin
            acc_q <= acc_q - $signed({1'b0, prod});
          end else begin
            acc_q <= acc_q + $signed({1'b0, prod});
          end
          state_q <= S_DIV_START;
        end
        S_DIV_START: begin
          // A zero band gives a zero sum; a negative sum clamps to zero.
          if (acc_q > 0) begin
            state_q <= S_DIV_WAIT;
          end else begin
            lux_q   <= '0;
            state_q <= S_DONE;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            lux_q   <= (div_rsp.quotient > LuxMaxQ8) ? LuxMaxQ8 : div_rsp.quotient;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // Advance once the output register is free or being taken.
          if (!out_valid_q || !out_stall_i) begin
            out_band_q  <= band_q;
            out_held0_q <= held0_q;
            out_held1_q <= held1_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // lux_q is stable while in S_DONE and until the next item reaches its result.
  logic [LuxW-1:0] out_lux_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_lux_q <= lux_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lux_q8_o          = out_lux_q;
  assign ratio_band_o      = out_band_q;
  assign held_visible_ir_o = out_held0_q;
  assign held_infrared_o   = out_held1_q;

endmodule
